// File: design/phpm_pkg.sv
package phpm_pkg;

    // Fixed geometry
    localparam int BIN_COUNT          = 256;
    localparam int BIN_W              = 8;
    localparam int KEY_W              = 32;
    localparam int OUT_W              = 32;
    localparam int USED_W             = 5;
    localparam int QUEUE_DEPTH        = 4;

    // Defaults for the top-level parameters
    localparam int PALETTE_DEPTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF    = 32;

    // Configuration port
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 5;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USED = 1'd1;

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PIXEL = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Operations passed from the front end to the count engine
    typedef enum logic [1:0] {
        OP_BUMP,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] bin;
    } cmd_t;

    typedef struct packed {
        logic              palette_mode;
        logic [USED_W-1:0] entries_used;
    } cfg_t;

endpackage

// File: design/phpm_in_if.sv
interface phpm_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [7:0]               alpha;
    logic [phpm_pkg::BIN_W-1:0] slot_index;

    modport source
    (
        output valid, req_type, red, green, blue, alpha, slot_index,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, red, green, blue, alpha, slot_index,
        output ready
    );
endinterface

// File: design/phpm_out_if.sv
interface phpm_out_if;
    logic                       valid;
    logic                       ready;
    logic [phpm_pkg::OUT_W-1:0] bin_count;
    logic [phpm_pkg::BIN_W-1:0] bin_number;

    modport source
    (
        output valid, bin_count, bin_number,
        input  ready
    );

    modport sink
    (
        input  valid, bin_count, bin_number,
        output ready
    );
endinterface

// File: design/phpm_front.sv
module phpm_front
#(
    parameter int PALETTE_DEPTH = phpm_pkg::PALETTE_DEPTH_DEF
)
(
    input  logic           clk,
    phpm_in_if.sink        req,
    input  phpm_pkg::cfg_t cfg,
    input  logic           full,
    output logic           push,
    output phpm_pkg::cmd_t push_cmd
);
    import phpm_pkg::*;

    localparam int PIDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [KEY_W-1:0] palette_reg [PALETTE_DEPTH];
    logic [KEY_W-1:0] key;
    logic             accept;
    logic [8:0]       used_lim;
    logic             hit;
    logic [BIN_W-1:0] hit_idx;
    logic             want_push;

    assign key       = {req.red, req.green, req.blue, req.alpha};
    assign req.ready = ~full;
    assign accept    = req.valid & req.ready;

    // Palette load; loads beyond the palette are dropped
    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == REQ_LOAD) && (int'(req.slot_index) < PALETTE_DEPTH))
        begin
            palette_reg[req.slot_index[PIDX_W-1:0]] <= key;
        end
    end

    // Number of entries taking part, clamped to the palette size
    always_comb
    begin
        if (9'(cfg.entries_used) > 9'(PALETTE_DEPTH))
        begin
            used_lim = 9'(PALETTE_DEPTH);
        end
        else
        begin
            used_lim = 9'(cfg.entries_used);
        end
    end

    // Parallel compare; later entries overwrite earlier ones, so highest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
        begin
            if ((9'(i) < used_lim) && (palette_reg[i] == key))
            begin
                hit     = 1'b1;
                hit_idx = BIN_W'(i);
            end
        end
    end

    // Classify the request
    always_comb
    begin
        want_push    = 1'b0;
        push_cmd.op  = OP_BUMP;
        push_cmd.bin = req.slot_index;
        unique case (req.req_type)
            REQ_PIXEL:
            begin
                if (!cfg.palette_mode)
                begin
                    want_push    = 1'b1;
                    push_cmd.bin = req.red;
                end
                else if (hit)
                begin
                    want_push    = 1'b1;
                    push_cmd.bin = hit_idx;
                end
            end
            REQ_READ:
            begin
                want_push   = 1'b1;
                push_cmd.op = OP_READ;
            end
            REQ_CLEAR:
            begin
                want_push   = 1'b1;
                push_cmd.op = OP_CLEAR;
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    assign push = accept & want_push;

endmodule

// File: design/phpm_queue.sv
module phpm_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  phpm_pkg::cmd_t push_cmd,
    input  logic           pop,
    output phpm_pkg::cmd_t pop_cmd,
    output logic           full,
    output logic           empty
);
    import phpm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: design/phpm_back.sv
module phpm_back
#(
    parameter int COUNT_WIDTH = phpm_pkg::COUNT_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  phpm_pkg::cmd_t pop_cmd,
    output logic           pop,
    phpm_out_if.source     rsp
);
    import phpm_pkg::*;

    logic [COUNT_WIDTH-1:0] count_mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [BIN_COUNT-1:0]   live_reg;

    logic                   b_valid_reg;
    cmd_t                   b_cmd_reg;

    logic                   fwd_valid_reg;
    logic [BIN_W-1:0]       fwd_bin_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_count_reg;
    logic [BIN_W-1:0]       out_bin_reg;

    logic                   advance;
    logic                   wr_en;
    logic                   do_clear;
    logic                   do_read;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   over_out;

    // The whole engine holds while a result waits untaken
    assign advance  = ~(out_valid_reg & ~rsp.ready);
    assign pop      = advance & ~empty;
    assign wr_en    = advance & b_valid_reg & (b_cmd_reg.op == OP_BUMP);
    assign do_clear = advance & b_valid_reg & (b_cmd_reg.op == OP_CLEAR);
    assign do_read  = b_valid_reg & (b_cmd_reg.op == OP_READ);

    // Current count: bypass the write made at the edge of our read, else memory
    always_comb
    begin
        if (fwd_valid_reg && (fwd_bin_reg == b_cmd_reg.bin))
        begin
            cur = fwd_data_reg;
        end
        else if (live_reg[b_cmd_reg.bin])
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    // Saturating increment and output clamp
    assign new_count = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + 1'b1;
    assign over_out  = |(cur >> OUT_W);

    // Count memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= count_mem[pop_cmd.bin];
        end
        if (wr_en)
        begin
            count_mem[b_cmd_reg.bin] <= new_count;
        end
    end

    // Per-bin valid bits; a clear drops them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (do_clear)
        begin
            live_reg <= '0;
        end
        else if (wr_en)
        begin
            live_reg[b_cmd_reg.bin] <= 1'b1;
        end
    end

    // Execute stage and bypass register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg   <= pop;
            fwd_valid_reg <= wr_en;
            out_valid_reg <= do_read;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pop)
            begin
                b_cmd_reg <= pop_cmd;
            end
            fwd_bin_reg  <= b_cmd_reg.bin;
            fwd_data_reg <= new_count;
            if (do_read)
            begin
                out_count_reg <= over_out ? {OUT_W{1'b1}} : OUT_W'(cur);
                out_bin_reg   <= b_cmd_reg.bin;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.bin_count  = out_count_reg;
    assign rsp.bin_number = out_bin_reg;

endmodule

// File: design/pixel_histogram_palette_match.sv
// Pixel histogram with palette match. Requests enter on req: palette loads,
// pixels, bin reads and clears. A pixel is counted into the bin given by its
// red byte (gray mode) or by the highest palette entry whose RGBA key it
// matches (palette mode); counts saturate. Each bin read gives one transfer on
// rsp, in request order. One request is taken per clock while the queue has
// room: a front end compares against the palette in parallel and classifies,
// a four-entry queue follows, and the count engine does read-modify-write on a
// single-port-pair count memory with a bypass, so a bump per clock is sustained
// even on one bin unless the engine stalls. A read result passes through the
// queue, the execute stage and the output register before it appears on rsp.
// req is held off only when the queue is full, which happens when a read
// result waits untaken on rsp and the engine stalls behind it. Clear drops a
// per-bin valid bit vector all at once, so reset needs no clearing pass.
// Configuration may be written only while no request is in flight.
module pixel_histogram_palette_match
#(
    parameter int PALETTE_DEPTH = phpm_pkg::PALETTE_DEPTH_DEF,
    parameter int COUNT_WIDTH   = phpm_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    phpm_in_if.sink                         req,
    phpm_out_if.source                      rsp,
    input  logic                            wr_en,
    input  logic [phpm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [phpm_pkg::CFG_DATA_W-1:0] wr_data
);
    import phpm_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t pop_cmd;
    logic full;
    logic empty;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PALETTE_MODE: cfg_next.palette_mode = wr_data[0];
                REG_ENTRIES_USED: cfg_next.entries_used = wr_data[USED_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    phpm_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk      (clk),
        .req      (req),
        .cfg      (cfg_reg),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    phpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (full),
        .empty    (empty)
    );

    phpm_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

// File: tb/phpm_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels, keeps its own copy of
// the palette and bin counts, and checks every bin read in order.
module phpm_checker
#(
    parameter int PALETTE_DEPTH = phpm_pkg::PALETTE_DEPTH_DEF,
    parameter int COUNT_WIDTH   = phpm_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    phpm_in_if                              req,
    phpm_out_if                             rsp,
    input  logic                            wr_en,
    input  logic [phpm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [phpm_pkg::CFG_DATA_W-1:0] wr_data,
    output int                              waiting,
    output int                              errors
);
    import phpm_pkg::*;

    localparam int PIDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic [BIN_W-1:0] bin;
    } bin_read_t;

    logic [KEY_W-1:0]       palette_keys [PALETTE_DEPTH];
    logic [COUNT_WIDTH-1:0] bin_counts [BIN_COUNT];
    logic                   cfg_palette_mode;
    logic [USED_W-1:0]      cfg_entries_used;
    bin_read_t              expected_reads [$];

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    // saturating increment
    task automatic bump_bin(input logic [BIN_W-1:0] bin);
        if (bin_counts[bin] != '1)
            bin_counts[bin] = bin_counts[bin] + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [KEY_W-1:0]       key;
        logic [COUNT_WIDTH-1:0] raw;
        int                     used;
        bin_read_t              want;

        if (!rst_n)
        begin
            foreach (palette_keys[i])
                palette_keys[i] = '0;
            foreach (bin_counts[i])
                bin_counts[i] = '0;
            cfg_palette_mode = 1'b0;
            cfg_entries_used = '0;
            expected_reads.delete();
            waiting = 0;
            errors  = 0;
        end
        else
        begin
            // register writes
            if (wr_en)
            begin
                if (wr_index == REG_PALETTE_MODE)
                    cfg_palette_mode = wr_data[0];
                else if (wr_index == REG_ENTRIES_USED)
                    cfg_entries_used = wr_data[USED_W-1:0];
            end

            // request transfer
            if (req.valid && req.ready)
            begin
                key = {req.red, req.green, req.blue, req.alpha};
                case (req.req_type)
                    REQ_LOAD:
                    begin
                        if (req.slot_index < PALETTE_DEPTH)
                            palette_keys[req.slot_index[PIDX_W-1:0]] = key;
                    end
                    REQ_PIXEL:
                    begin
                        if (!cfg_palette_mode)
                            bump_bin(req.red);
                        else
                        begin
                            used = (cfg_entries_used > PALETTE_DEPTH) ? PALETTE_DEPTH
                                                                      : cfg_entries_used;
                            // highest matching entry wins
                            for (int i = used - 1; i >= 0; i--)
                            begin
                                if (palette_keys[i] == key)
                                begin
                                    bump_bin(BIN_W'(i));
                                    break;
                                end
                            end
                        end
                    end
                    REQ_READ:
                    begin
                        raw = bin_counts[req.slot_index];
                        if (COUNT_WIDTH > OUT_W && (raw >> OUT_W) != 0)
                            want.count = '1;
                        else
                            want.count = OUT_W'(raw);
                        want.bin = req.slot_index;
                        expected_reads.push_back(want);
                    end
                    REQ_CLEAR:
                    begin
                        foreach (bin_counts[i])
                            bin_counts[i] = '0;
                    end
                endcase
            end

            // result transfer
            if (rsp.valid && rsp.ready)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch("unrequested result", rsp.bin_count, '0);
                else
                begin
                    want = expected_reads.pop_front();
                    if (rsp.bin_count !== want.count)
                        report_mismatch("bin_count", rsp.bin_count, want.count);
                    if (rsp.bin_number !== want.bin)
                        report_mismatch("bin_number", OUT_W'(rsp.bin_number),
                                        OUT_W'(want.bin));
                end
            end

            waiting = expected_reads.size();
        end
    end

endmodule

// File: tb/tb_pixel_histogram_palette_match.sv
`timescale 1ns / 100ps

module tb_pixel_histogram_palette_match;

    import phpm_pkg::*;

    localparam int          PAL_DEPTH = PALETTE_DEPTH_DEF;
    localparam int          PIDX_W    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int          SETTLE    = 16;
    localparam logic [31:0] DUP_KEY   = 32'h1357_9BDF;
    localparam logic [31:0] ALIEN_KEY = 32'hCAFE_F00D;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    waiting;
    int                    errors;

    // stimulus shaping state
    bit                    steady;
    logic                  palette_on;
    logic [31:0]           loaded_keys [PAL_DEPTH];

    phpm_in_if  req_ch();
    phpm_out_if rsp_ch();

    pixel_histogram_palette_match i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    phpm_checker i_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .waiting  (waiting),
        .errors   (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                                input logic [7:0] slot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.red        <= key[31:24];
        req_ch.green      <= key[23:16];
        req_ch.blue       <= key[15:8];
        req_ch.alpha      <= key[7:0];
        req_ch.slot_index <= slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        if (kind == REQ_LOAD && slot < PAL_DEPTH)
            loaded_keys[slot[PIDX_W-1:0]] = key;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // drain all reads, then let silent requests leave the pipeline
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic random_request();
        int          roll;
        logic [31:0] key;
        logic [7:0]  slot;
        roll = $urandom_range(99);
        key  = $urandom;
        slot = 8'($urandom);
        if (roll < 50)
        begin
            // pixels: in palette mode mostly hit a loaded key
            if (palette_on && $urandom_range(3) != 0)
                key = loaded_keys[PIDX_W'($urandom_range(PAL_DEPTH-1))];
            else if (!palette_on && $urandom_range(4) < 2)
                key[31:24] = 8'($urandom_range(7));
            send_request(REQ_PIXEL, key, slot);
        end
        else if (roll < 80)
        begin
            // reads concentrate on bins that are likely to be busy
            if ($urandom_range(9) < 7)
                slot = palette_on ? 8'($urandom_range(PAL_DEPTH-1)) : 8'($urandom_range(7));
            send_request(REQ_READ, key, slot);
        end
        else if (roll < 97)
        begin
            if ($urandom_range(99) < 85)
                slot = 8'($urandom_range(PAL_DEPTH-1));
            else
                slot = 8'($urandom_range(255, PAL_DEPTH));
            if ($urandom_range(9) < 3)
                key = loaded_keys[PIDX_W'($urandom_range(PAL_DEPTH-1))];
            send_request(REQ_LOAD, key, slot);
        end
        else
            send_request(REQ_CLEAR, key, slot);
    endtask

    // result side back-pressure
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // stimulus
    initial
    begin
        int          used_plan [4];
        logic        mode;
        logic [4:0]  used;
        logic [31:0] key;

        used_plan = '{0, 16, 31, 5};
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_LOAD;
        req_ch.red         = '0;
        req_ch.green       = '0;
        req_ch.blue        = '0;
        req_ch.alpha       = '0;
        req_ch.slot_index  = '0;
        steady             = 1'b0;
        palette_on         = 1'b0;
        foreach (loaded_keys[i])
            loaded_keys[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // gray mode after reset: fill the palette, with one duplicated key
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            if (i == 0)
                key = 32'h0000_0000;
            else if (i == PAL_DEPTH - 1)
                key = 32'hFFFF_FFFF;
            else if (i == 3 || i == 9)
                key = DUP_KEY;
            else
                key = $urandom;
            send_request(REQ_LOAD, key, i[7:0]);
        end
        // loads beyond the palette are dropped
        send_request(REQ_LOAD, ALIEN_KEY, 8'd16);
        send_request(REQ_LOAD, ALIEN_KEY, 8'd255);
        send_request(REQ_PIXEL, 32'hFFFF_FFFF, 8'd255);
        send_request(REQ_PIXEL, 32'h0000_0000, 8'd0);
        send_request(REQ_READ, 32'h0, 8'd0);
        send_request(REQ_READ, 32'h0, 8'd255);
        send_request(REQ_READ, 32'h0, 8'd128);
        send_request(REQ_CLEAR, 32'h0, 8'd0);
        send_request(REQ_READ, 32'h0, 8'd255);
        settle();

        // palette mode, full palette: duplicates, extremes and a miss
        write_reg(REG_PALETTE_MODE, 5'd1);
        write_reg(REG_ENTRIES_USED, 5'd16);
        palette_on = 1'b1;
        send_request(REQ_PIXEL, DUP_KEY, 8'd0);
        send_request(REQ_PIXEL, 32'h0000_0000, 8'd0);
        send_request(REQ_PIXEL, 32'hFFFF_FFFF, 8'd0);
        send_request(REQ_PIXEL, ALIEN_KEY, 8'd0);
        send_request(REQ_READ, 32'h0, 8'd9);
        send_request(REQ_READ, 32'h0, 8'd3);
        send_request(REQ_READ, 32'h0, 8'd0);
        send_request(REQ_READ, 32'h0, 8'd15);
        settle();

        // random phases over a spread of settings
        for (int p = 0; p < 10; p++)
        begin
            mode = (p < 3) ? 1'b1 : (p == 3) ? 1'b0 : 1'($urandom_range(1));
            used = (p < 4) ? 5'(used_plan[p]) : 5'($urandom_range(31));
            steady = ($urandom_range(3) == 0);
            if ($urandom_range(1))
            begin
                write_reg(REG_PALETTE_MODE, {4'd0, mode});
                write_reg(REG_ENTRIES_USED, used);
            end
            else
            begin
                write_reg(REG_ENTRIES_USED, used);
                write_reg(REG_PALETTE_MODE, {4'd0, mode});
            end
            palette_on = mode;
            repeat (60) random_request();
            settle();
        end

        if (errors == 0 && waiting == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
